### sv/nrld_pkg.sv
// Shared types and constants for the nibble run-length decoder.
package nrld_pkg;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAW_MODE   = 1'b1;

  localparam int CFG_DATA_W = 8;
  localparam int BYTE_W     = 8;
  localparam int NIB_W      = 4;
  localparam int MAX_TILES  = 256;

  typedef enum logic [1:0] {
    S_IDLE,
    S_NIB,
    S_RUN,
    S_RAW
  } state_t;

  // One decoded word handed to the output register.
  typedef struct packed {
    logic              vld;
    logic [BYTE_W-1:0] data;
    logic              last;
  } push_t;

endpackage

### sv/nrld_obuf.sv
// Output register of the nibble run-length decoder, one word deep.
module nrld_obuf (
  input  logic                  clk,
  input  logic                  rst_n,
  input  nrld_pkg::push_t       push,
  output logic                  slot_free,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_byte,
  output logic                  out_last
);
  import nrld_pkg::*;

  logic              valid_r, valid_nxt;
  logic [BYTE_W-1:0] data_r, data_nxt;
  logic              last_r, last_nxt;

  // The slot frees in the same cycle the waiting word leaves.
  assign slot_free = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = push.vld || (valid_r && out_stall);
    data_nxt  = data_r;
    last_nxt  = last_r;
    if (push.vld) begin
      data_nxt = push.data;
      last_nxt = push.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    data_r <= data_nxt;
    last_r <= last_nxt;
  end

  assign out_valid = valid_r;
  assign out_byte  = data_r;
  assign out_last  = last_r;

endmodule

### sv/nibble_run_length_decoder_top.sv
// Nibble run-length decoder top level: byte intake, nibble sequencer, run counter.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------
//   in      | input     | in_valid / in_stall  | in_stream_byte, in_first
//   out     | output    | out_valid / out_stall| out_byte, out_last
//   cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// A byte is taken in S_IDLE, then each nibble passes through the
// nibble sequencer, and the run counter puts the repeated nibble count+1
// times, counting down from the count nibble to zero. Raw mode passes each byte whole.
// A new byte is taken only once the previous one is fully decoded. Reset clears
// config and decode state; a stalled output holds the sequencer only when a put
// would complete a word while a finished word waits in the output register.
module nibble_run_length_decoder_top #(
  parameter int BYTES_PER_TILE = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_stream_byte,
  input  logic                           in_first,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_byte,
  output logic                           out_last,
  input  logic                           cfg_we,
  input  logic [nrld_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nrld_pkg::CFG_DATA_W-1:0] cfg_data
);
  import nrld_pkg::*;

  localparam int TOT_W  = $clog2(MAX_TILES * BYTES_PER_TILE + 1);
  localparam int TILE_W = $clog2(MAX_TILES + 1);

  state_t state_r, state_nxt;

  logic [7:0]        tile_count_r;
  logic              raw_mode_r;

  logic [BYTE_W-1:0] sh_r, sh_nxt;
  logic              nib_left_r, nib_left_nxt;
  logic [NIB_W-1:0]  prev_r, prev_nxt;
  logic              prev_valid_r, prev_valid_nxt;
  logic              awaiting_r, awaiting_nxt;
  logic [NIB_W-1:0]  pending_r, pending_nxt;
  logic              half_r, half_nxt;
  logic [TOT_W-1:0]  bytes_done_r, bytes_done_nxt;
  logic [NIB_W-1:0]  run_left_r, run_left_nxt;

  logic [TILE_W-1:0] tiles;
  logic [TOT_W-1:0]  total;
  logic [TOT_W-1:0]  bd_inc;
  logic              done;
  logic              accept;
  logic [NIB_W-1:0]  nib;
  logic              is_match;
  logic              is_put;
  logic [NIB_W-1:0]  put_n;
  logic              put_blocked;
  logic              slot_free;
  push_t             push;

  assign tiles  = (tile_count_r == 8'd0) ? TILE_W'(MAX_TILES) : TILE_W'(tile_count_r);
  assign total  = TOT_W'(tiles) * TOT_W'(BYTES_PER_TILE);
  assign bd_inc = bytes_done_r + TOT_W'(1);
  assign done   = (bytes_done_r >= total);

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  assign nib      = sh_r[BYTE_W-1 -: NIB_W];
  assign is_match = prev_valid_r && (nib == prev_r);

  always_comb begin
    is_put = 1'b0;
    put_n  = nib;
    case (state_r)
      S_NIB: begin
        is_put = !done && !awaiting_r && !is_match;
      end
      S_RUN: begin
        is_put = !done;
        put_n  = prev_r;
      end
      default: begin
        is_put = 1'b0;
      end
    endcase
  end

  // A put that completes a word must wait for the output slot.
  assign put_blocked = is_put && half_r && !slot_free;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = raw_mode_r ? S_RAW : S_NIB;
        end
      end
      S_RAW: begin
        if (done || slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_NIB: begin
        if (done) begin
          state_nxt = S_IDLE;
        end else if (awaiting_r) begin
          state_nxt = S_RUN;
        end else if (!put_blocked) begin
          state_nxt = nib_left_r ? S_NIB : S_IDLE;
        end
      end
      S_RUN: begin
        if (done) begin
          state_nxt = S_IDLE;
        end else if (!put_blocked && run_left_r == '0) begin
          state_nxt = nib_left_r ? S_NIB : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Datapath and decode state
  always_comb begin
    sh_nxt         = sh_r;
    nib_left_nxt   = nib_left_r;
    prev_nxt       = prev_r;
    prev_valid_nxt = prev_valid_r;
    awaiting_nxt   = awaiting_r;
    pending_nxt    = pending_r;
    half_nxt       = half_r;
    bytes_done_nxt = bytes_done_r;
    run_left_nxt   = run_left_r;
    push           = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          sh_nxt       = in_stream_byte;
          nib_left_nxt = 1'b1;
          if (in_first) begin
            prev_nxt       = '0;
            prev_valid_nxt = 1'b0;
            awaiting_nxt   = 1'b0;
            pending_nxt    = '0;
            half_nxt       = 1'b0;
            bytes_done_nxt = '0;
          end
        end
      end
      S_RAW: begin
        if (!done && slot_free) begin
          push.vld       = 1'b1;
          push.data      = sh_r;
          push.last      = (bd_inc == total);
          bytes_done_nxt = bd_inc;
        end
      end
      S_NIB: begin
        if (!done && !put_blocked) begin
          // consume the high nibble and shift the low one up
          sh_nxt       = {sh_r[NIB_W-1:0], NIB_W'(0)};
          nib_left_nxt = 1'b0;
          if (awaiting_r) begin
            // keep track of a low nibble still due after the run
            nib_left_nxt   = nib_left_r;
            run_left_nxt   = nib;
            awaiting_nxt   = 1'b0;
            prev_valid_nxt = 1'b0;
          end else if (is_match) begin
            awaiting_nxt = 1'b1;
          end else begin
            prev_nxt       = nib;
            prev_valid_nxt = 1'b1;
          end
        end
      end
      S_RUN: begin
        if (!done && !put_blocked && run_left_r != '0) begin
          run_left_nxt = run_left_r - NIB_W'(1);
        end else if (!done && !put_blocked) begin
          nib_left_nxt = 1'b0;
        end
      end
      default: begin
        push = '0;
      end
    endcase

    // pack nibbles two to a word
    if (is_put && !put_blocked) begin
      if (!half_r) begin
        pending_nxt = put_n;
        half_nxt    = 1'b1;
      end else begin
        push.vld       = 1'b1;
        push.data      = {pending_r, put_n};
        push.last      = (bd_inc == total);
        half_nxt       = 1'b0;
        bytes_done_nxt = bd_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      tile_count_r <= '0;
      raw_mode_r   <= 1'b0;
      prev_r       <= '0;
      prev_valid_r <= 1'b0;
      awaiting_r   <= 1'b0;
      pending_r    <= '0;
      half_r       <= 1'b0;
      bytes_done_r <= '0;
      nib_left_r   <= 1'b0;
      run_left_r   <= '0;
    end else begin
      state_r      <= state_nxt;
      prev_r       <= prev_nxt;
      prev_valid_r <= prev_valid_nxt;
      awaiting_r   <= awaiting_nxt;
      pending_r    <= pending_nxt;
      half_r       <= half_nxt;
      bytes_done_r <= bytes_done_nxt;
      nib_left_r   <= nib_left_nxt;
      run_left_r   <= run_left_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_TILE_COUNT: tile_count_r <= cfg_data;
          CFG_RAW_MODE:   raw_mode_r   <= cfg_data[0];
          default:        raw_mode_r   <= raw_mode_r;
        endcase
      end
    end
    sh_r <= sh_nxt;
  end

  nrld_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

  a_push_slot: assert property (@(posedge clk) disable iff (!rst_n)
    push.vld |-> slot_free)
    else $error("word pushed while output register is occupied");

  a_push_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    push.vld |=> (bytes_done_r == $past(bd_inc)))
    else $error("byte count out of step with pushed words");

  a_run_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> (!awaiting_r && !prev_valid_r))
    else $error("run in progress with stale literal state");

  a_pair_half: assert property (@(posedge clk) disable iff (!rst_n)
    (push.vld && state_r != S_RAW) |-> half_r)
    else $error("nibble word pushed without a pending nibble");

endmodule
